// ===== rtl/mm3_pkg.sv =====
package mm3_pkg;

    localparam logic [31:0] C_SEED_RESET = 32'hc2b2ae35;
    localparam logic [63:0] C_MUL_1      = 64'h87c37b91114253d5;
    localparam logic [63:0] C_MUL_2      = 64'h4cf5ad432745937f;
    localparam logic [63:0] C_FMIX_1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] C_FMIX_2     = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] C_ADD_A      = 64'h0000000052dce729;
    localparam logic [63:0] C_ADD_B      = 64'h0000000038495ab5;

    localparam int C_BLOCK_BYTES = 16;
    localparam int C_FILL_W      = 5;
    localparam int C_PC_W        = 6;

    typedef logic [C_FILL_W-1:0] t_fill;
    typedef logic [C_PC_W-1:0]   t_pc;

    typedef enum logic [4:0] {
        OP_LDK_W0,
        OP_LDK_W1,
        OP_LDK_A,
        OP_LDK_B,
        OP_MUL_C1,
        OP_MUL_C2,
        OP_MUL_C3,
        OP_MUL_C4,
        OP_ROT31,
        OP_ROT33,
        OP_FMIX,
        OP_XA,
        OP_XB,
        OP_AROT,
        OP_A5,
        OP_BROT,
        OP_B5,
        OP_XLEN,
        OP_AADDB,
        OP_BADDA,
        OP_STA,
        OP_STB,
        OP_END_MIX,
        OP_END_FIN
    } t_op;

    localparam t_pc PC_MIX    = 6'd0;
    localparam t_pc PC_TAIL_B = 6'd15;
    localparam t_pc PC_TAIL_A = 6'd20;
    localparam t_pc PC_FINAL  = 6'd25;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       is_last;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] y;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

    // Microprogram: block mix, then the two tail folds, then finalization.
    function automatic t_op prog_op(t_pc pc);
        t_op op;
        unique case (pc)
            6'd0:    op = OP_LDK_W0;
            6'd1:    op = OP_MUL_C1;
            6'd2:    op = OP_ROT31;
            6'd3:    op = OP_MUL_C2;
            6'd4:    op = OP_XA;
            6'd5:    op = OP_AROT;
            6'd6:    op = OP_A5;
            6'd7:    op = OP_LDK_W1;
            6'd8:    op = OP_MUL_C2;
            6'd9:    op = OP_ROT33;
            6'd10:   op = OP_MUL_C1;
            6'd11:   op = OP_XB;
            6'd12:   op = OP_BROT;
            6'd13:   op = OP_B5;
            6'd14:   op = OP_END_MIX;
            6'd15:   op = OP_LDK_W1;
            6'd16:   op = OP_MUL_C2;
            6'd17:   op = OP_ROT33;
            6'd18:   op = OP_MUL_C1;
            6'd19:   op = OP_XB;
            6'd20:   op = OP_LDK_W0;
            6'd21:   op = OP_MUL_C1;
            6'd22:   op = OP_ROT31;
            6'd23:   op = OP_MUL_C2;
            6'd24:   op = OP_XA;
            6'd25:   op = OP_XLEN;
            6'd26:   op = OP_AADDB;
            6'd27:   op = OP_BADDA;
            6'd28:   op = OP_LDK_A;
            6'd29:   op = OP_FMIX;
            6'd30:   op = OP_MUL_C3;
            6'd31:   op = OP_FMIX;
            6'd32:   op = OP_MUL_C4;
            6'd33:   op = OP_FMIX;
            6'd34:   op = OP_STA;
            6'd35:   op = OP_LDK_B;
            6'd36:   op = OP_FMIX;
            6'd37:   op = OP_MUL_C3;
            6'd38:   op = OP_FMIX;
            6'd39:   op = OP_MUL_C4;
            6'd40:   op = OP_FMIX;
            6'd41:   op = OP_STB;
            6'd42:   op = OP_AADDB;
            6'd43:   op = OP_BADDA;
            default: op = OP_END_FIN;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/mm3_if.sv =====
interface mm3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       is_last;

    modport source(output valid, output byte_value, output has_byte, output is_last,
                   input ready);
    modport sink(input valid, input byte_value, input has_byte, input is_last,
                 output ready);
endinterface

interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_low;
    logic [63:0] hash_high;

    modport source(output valid, output hash_low, output hash_high, input ready);
    modport sink(input valid, input hash_low, input hash_high, output ready);
endinterface

interface mm3_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;

    modport source(output valid, output seed, input ready);
    modport sink(input valid, input seed, output ready);
endinterface

// ===== rtl/mm3_mul.sv =====
module mm3_mul
    import mm3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic        r_busy;
    logic [1:0]  r_step;
    logic        r_done;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_m;
    logic [63:0] r_acc;
    logic [31:0] w_mx;
    logic [31:0] w_my;
    logic [63:0] w_prod;

    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_mx = r_x[31:0];
                w_my = r_y[31:0];
            end
            2'd1: begin
                w_mx = r_x[31:0];
                w_my = r_y[63:32];
            end
            2'd2: begin
                w_mx = r_x[63:32];
                w_my = r_y[31:0];
            end
            2'd3: begin
                w_mx = r_x[63:32];
                w_my = r_y[63:32];
            end
        endcase
    end

    assign w_prod = 64'(w_mx) * 64'(w_my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The low 64 bits need only the low halves of the two cross products.
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_x <= i_req.x;
            r_y <= i_req.y;
        end
        r_m <= w_prod;
        if (r_busy) begin
            if (r_step == 2'd1) begin
                r_acc <= r_m;
            end else if (r_step != 2'd0) begin
                r_acc <= r_acc + {r_m[31:0], 32'h0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

// ===== rtl/mm3_core.sv =====
module mm3_core
    import mm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_item       i_item,
    input  logic        i_cfg_wr,
    input  logic [31:0] i_cfg_seed,
    input  logic        i_res_ready,
    input  t_mul_rsp    i_mul_rsp,
    output t_mul_req    o_mul_req,
    output logic        o_idle,
    output logic        o_res_valid,
    output logic [63:0] o_hash_low,
    output logic [63:0] o_hash_high
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_MULW = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_pc         r_pc, n_pc;
    t_fill       r_fill, n_fill;
    logic        r_last_pend, n_last_pend;
    logic [31:0] r_seed, n_seed;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_k, n_k;
    logic [63:0] r_len, n_len;
    logic [7:0]  r_buf [C_BLOCK_BYTES];
    logic [63:0] w_word0;
    logic [63:0] w_word1;
    t_fill       w_fill_inc;
    t_op         w_op;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_word0[8*i +: 8] = (C_FILL_W'(i) < r_fill) ? r_buf[i] : 8'h00;
            w_word1[8*i +: 8] = (C_FILL_W'(i + 8) < r_fill) ? r_buf[i + 8] : 8'h00;
        end
    end

    assign w_op       = prog_op(r_pc);
    assign w_fill_inc = r_fill + C_FILL_W'(i_item.has_byte);

    always_comb begin
        o_mul_req.start = 1'b0;
        o_mul_req.x     = r_k;
        o_mul_req.y     = C_MUL_1;
        if (r_state == S_RUN) begin
            unique case (w_op)
                OP_MUL_C1: begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.y     = C_MUL_1;
                end
                OP_MUL_C2: begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.y     = C_MUL_2;
                end
                OP_MUL_C3: begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.y     = C_FMIX_1;
                end
                OP_MUL_C4: begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.y     = C_FMIX_2;
                end
                default: begin
                    o_mul_req.start = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_fill      = r_fill;
        n_last_pend = r_last_pend;
        n_seed      = r_seed;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_len       = r_len;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_wr) begin
                    n_seed = i_cfg_seed;
                    n_a    = {32'h0, i_cfg_seed};
                    n_b    = {32'h0, i_cfg_seed};
                    n_fill = '0;
                    n_len  = '0;
                end else if (i_acc) begin
                    n_fill = w_fill_inc;
                    if (i_item.has_byte) begin
                        n_len = r_len + 64'd1;
                    end
                    if (w_fill_inc == C_FILL_W'(C_BLOCK_BYTES)) begin
                        n_state     = S_RUN;
                        n_pc        = PC_MIX;
                        n_last_pend = i_item.is_last;
                    end else if (i_item.is_last) begin
                        n_state = S_RUN;
                        priority if (w_fill_inc > C_FILL_W'(8)) begin
                            n_pc = PC_TAIL_B;
                        end else if (w_fill_inc != '0) begin
                            n_pc = PC_TAIL_A;
                        end else begin
                            n_pc = PC_FINAL;
                        end
                    end
                end
            end
            S_MULW: begin
                if (i_mul_rsp.done) begin
                    n_k     = i_mul_rsp.p;
                    n_pc    = r_pc + C_PC_W'(1);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_pc = r_pc + C_PC_W'(1);
                unique case (w_op)
                    OP_LDK_W0: n_k = w_word0;
                    OP_LDK_W1: n_k = w_word1;
                    OP_LDK_A:  n_k = r_a;
                    OP_LDK_B:  n_k = r_b;
                    OP_MUL_C1, OP_MUL_C2, OP_MUL_C3, OP_MUL_C4: begin
                        n_pc    = r_pc;
                        n_state = S_MULW;
                    end
                    OP_ROT31:  n_k = {r_k[32:0], r_k[63:33]};
                    OP_ROT33:  n_k = {r_k[30:0], r_k[63:31]};
                    OP_FMIX:   n_k = r_k ^ {33'h0, r_k[63:33]};
                    OP_XA:     n_a = r_a ^ r_k;
                    OP_XB:     n_b = r_b ^ r_k;
                    OP_AROT:   n_a = {r_a[36:0], r_a[63:37]} + r_b;
                    OP_A5:     n_a = r_a + {r_a[61:0], 2'b00} + C_ADD_A;
                    OP_BROT:   n_b = {r_b[32:0], r_b[63:33]} + r_a;
                    OP_B5:     n_b = r_b + {r_b[61:0], 2'b00} + C_ADD_B;
                    OP_XLEN: begin
                        n_a = r_a ^ r_len;
                        n_b = r_b ^ r_len;
                    end
                    OP_AADDB:  n_a = r_a + r_b;
                    OP_BADDA:  n_b = r_b + r_a;
                    OP_STA:    n_a = r_k;
                    OP_STB:    n_b = r_k;
                    OP_END_MIX: begin
                        n_fill = '0;
                        if (r_last_pend) begin
                            n_pc = PC_FINAL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    OP_END_FIN: begin
                        if (i_res_ready) begin
                            o_res_valid = 1'b1;
                            n_a         = {32'h0, r_seed};
                            n_b         = {32'h0, r_seed};
                            n_fill      = '0;
                            n_len       = '0;
                            n_state     = S_IDLE;
                        end else begin
                            n_pc = r_pc;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= PC_MIX;
            r_fill      <= '0;
            r_last_pend <= 1'b0;
            r_seed      <= C_SEED_RESET;
            r_a         <= {32'h0, C_SEED_RESET};
            r_b         <= {32'h0, C_SEED_RESET};
            r_len       <= '0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_fill      <= n_fill;
            r_last_pend <= n_last_pend;
            r_seed      <= n_seed;
            r_a         <= n_a;
            r_b         <= n_b;
            r_len       <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (r_state == S_IDLE && !i_cfg_wr && i_acc && i_item.has_byte) begin
            r_buf[r_fill[3:0]] <= i_item.byte_value;
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_hash_low  = r_a;
    assign o_hash_high = r_b;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= C_FILL_W'(C_BLOCK_BYTES))
        else $error("Buffer fill count is out of range.");

    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |-> (r_state == S_IDLE))
        else $error("An item was accepted while the engine was busy.");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_state == S_IDLE && r_fill == '0 && r_len == '0))
        else $error("The engine did not restart after a result.");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_rsp.done |-> (r_state == S_MULW))
        else $error("A product arrived while no multiply was pending.");
`endif

endmodule

// ===== rtl/murmur3_128_stream_hash_top.sv =====
// Channel  Direction  Payload                          Transfer
// i_in     in         byte_value, has_byte, is_last    valid && ready
// o_out    out        hash_low, hash_high              valid && ready
// i_cfg    in         seed                             valid && ready
//
// An item that only adds a byte is buffered; a byte that completes a 16-byte
// block also starts the block mixing.
// The last item of a message runs one tail fold for a tail of up to 8 bytes, two for
// a longer tail and none for no tail, then finalization; 64-bit multiplies use the
// shared 32x32 multiplier; a last byte that completes a block adds the mixing too.
// Reset is synchronous and active low; the seed returns to its default value.
// A finished hash waits in the output register while the next message goes on; that
// message stalls at its own result only while the register is still full.
module murmur3_128_stream_hash_top
    import mm3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    mm3_in_if.sink     i_in,
    mm3_out_if.source  o_out,
    mm3_cfg_if.sink    i_cfg
);

    t_mul_req    w_mul_req;
    t_mul_rsp    w_mul_rsp;
    t_item       w_item;
    logic        w_idle;
    logic        w_res_valid;
    logic        w_res_ready;
    logic [63:0] w_hash_low;
    logic [63:0] w_hash_high;
    logic        w_in_acc;
    logic        w_cfg_wr;
    logic        r_out_valid;
    logic [63:0] r_hash_low;
    logic [63:0] r_hash_high;

    assign i_cfg.ready = w_idle;
    assign i_in.ready  = w_idle && !i_cfg.valid;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_res_ready = !r_out_valid || o_out.ready;

    assign w_item.byte_value = i_in.byte_value;
    assign w_item.has_byte   = i_in.has_byte;
    assign w_item.is_last    = i_in.is_last;

    mm3_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    mm3_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_in_acc),
        .i_item      (w_item),
        .i_cfg_wr    (w_cfg_wr),
        .i_cfg_seed  (i_cfg.seed),
        .i_res_ready (w_res_ready),
        .i_mul_rsp   (w_mul_rsp),
        .o_mul_req   (w_mul_req),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_hash_low  (w_hash_low),
        .o_hash_high (w_hash_high)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_hash_low  <= w_hash_low;
            r_hash_high <= w_hash_high;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.hash_low  = r_hash_low;
    assign o_out.hash_high = r_hash_high;

endmodule
